/* design/nss_pkg.sv */
// nss_pkg: shared constants, state codes and character helpers for name similarity scoring
// no dependencies; imported by name_similarity_score
package nss_pkg;

  localparam int MAX_LEN  = 64;
  localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int CHAR_W   = 16;
  localparam int OP_W     = 2;
  localparam int SIM_W    = 10;
  localparam int SCALE_SH = 8;
  localparam int NUM_W    = LEN_W + SCALE_SH;
  localparam int CNT_W    = $clog2(NUM_W + 1);

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_SCORE  = 2'd2;

  localparam logic signed [SIM_W-1:0] SCORE_FULL   = 10'sd200;
  localparam logic signed [SIM_W-1:0] SCORE_REJECT = -10'sd1;

  localparam logic [CHAR_W-1:0] UPPER_LO   = 16'h0041;
  localparam logic [CHAR_W-1:0] UPPER_HI   = 16'h005A;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 16'h0020;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_PRE_RD  = 7'b0000010,
    ST_PRE_CMP = 7'b0000100,
    ST_SUF_RD  = 7'b0001000,
    ST_SUF_CMP = 7'b0010000,
    ST_EVAL    = 7'b0100000,
    ST_DIV     = 7'b1000000
  } state_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] f;
    f = c;
    if (c >= UPPER_LO && c <= UPPER_HI) begin
      f = c + CASE_DELTA;
    end
    return f;
  endfunction

  function automatic logic chars_alike(input logic [CHAR_W-1:0] x,
                                       input logic [CHAR_W-1:0] y);
    return fold_char(x) == fold_char(y);
  endfunction

endpackage

/* design/nss_ram.sv */
// nss_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies
module nss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/name_similarity_score.sv */
// name_similarity_score: load transactions are accepted back to back
// score transaction rejected on length: busy stays low, result strobe in the cycle after accept
// other score transactions: busy through the walk states, if any (a read and a compare per
// character), the evaluate state and, for a ratio score, the divide state; strobe in the next cycle
// busy is high while a score transaction runs; the receiver cannot stall
// synchronous active-low reset clears lengths, overflow flag, fsm and strobe; rams undefined
module name_similarity_score (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [nss_pkg::OP_W-1:0]           in_op,
  input  logic [nss_pkg::CHAR_W-1:0]         in_char_code,
  output logic                               out_valid,
  output logic signed [nss_pkg::SIM_W-1:0]   out_similarity,
  output logic                               out_too_long
);
  import nss_pkg::*;

  state_t state_r, state_nxt;
  logic [LEN_W-1:0] length_a_r, length_a_nxt;
  logic [LEN_W-1:0] length_b_r, length_b_nxt;
  logic             overflow_r, overflow_nxt;
  logic             swap_r, swap_nxt;
  logic [LEN_W-1:0] len1_r, len1_nxt;
  logic [LEN_W-1:0] len2_r, len2_nxt;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic [LEN_W-1:0] tol_r, tol_nxt;
  logic             neg_r, neg_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic signed [SIM_W-1:0] out_sim_r, out_sim_nxt;
  logic             out_too_long_r, out_too_long_nxt;

  logic              accept;
  logic              we_a, we_b;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [CHAR_W-1:0] rdata_a, rdata_b;
  logic [ADDR_W-1:0] s1_addr, s2_addr;
  logic              alike;

  logic              swap_now;
  logic [LEN_W-1:0]  len1_now, len2_now;
  logic [LEN_W-1:0]  unmatched, matched, tol_now, i_inc, k_dec;
  logic [LEN_W:0]    trial;
  logic              qbit;
  logic [NUM_W-1:0]  quo_step;
  logic [SIM_W-1:0]  quo_mag;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  assign we_a = accept && (in_op == OP_LOAD_A) && (length_a_r < LEN_W'(MAX_LEN));
  assign we_b = accept && (in_op == OP_LOAD_B) && (length_b_r < LEN_W'(MAX_LEN));

  assign s1_addr = ADDR_W'(k_r - 1'b1);
  assign s2_addr = ADDR_W'(k_r + len2_r - len1_r - 1'b1);

  always_comb begin
    raddr_a = i_r[ADDR_W-1:0];
    raddr_b = i_r[ADDR_W-1:0];
    if (state_r == ST_SUF_RD) begin
      raddr_a = swap_r ? s2_addr : s1_addr;
      raddr_b = swap_r ? s1_addr : s2_addr;
    end
  end

  nss_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_ram_a (
    .clk     (clk),
    .wr_en   (we_a),
    .wr_addr (length_a_r[ADDR_W-1:0]),
    .wr_data (in_char_code),
    .rd_addr (raddr_a),
    .rd_data (rdata_a)
  );

  nss_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_ram_b (
    .clk     (clk),
    .wr_en   (we_b),
    .wr_addr (length_b_r[ADDR_W-1:0]),
    .wr_data (in_char_code),
    .rd_addr (raddr_b),
    .rd_data (rdata_b)
  );

  assign alike = chars_alike(rdata_a, rdata_b);

  assign swap_now  = length_a_r > length_b_r;
  assign len1_now  = swap_now ? length_b_r : length_a_r;
  assign len2_now  = swap_now ? length_a_r : length_b_r;
  assign unmatched = k_r - i_r;
  assign matched   = len1_r - unmatched;
  assign tol_now   = (len1_r >> 2) + 1'b1;
  assign i_inc     = i_r + 1'b1;
  assign k_dec     = k_r - 1'b1;

  assign trial    = {rem_r, quo_r[NUM_W-1]};
  assign qbit     = trial >= {1'b0, tol_r};
  assign quo_step = {quo_r[NUM_W-2:0], qbit};
  assign quo_mag  = SIM_W'(quo_step);

  always_comb begin
    state_nxt        = state_r;
    length_a_nxt     = length_a_r;
    length_b_nxt     = length_b_r;
    overflow_nxt     = overflow_r;
    swap_nxt         = swap_r;
    len1_nxt         = len1_r;
    len2_nxt         = len2_r;
    i_nxt            = i_r;
    k_nxt            = k_r;
    tol_nxt          = tol_r;
    neg_nxt          = neg_r;
    quo_nxt          = quo_r;
    rem_nxt          = rem_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = 1'b0;
    out_sim_nxt      = out_sim_r;
    out_too_long_nxt = out_too_long_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_LOAD_A: begin
              if (we_a) begin
                length_a_nxt = length_a_r + 1'b1;
              end else begin
                overflow_nxt = 1'b1;
              end
            end
            OP_LOAD_B: begin
              if (we_b) begin
                length_b_nxt = length_b_r + 1'b1;
              end else begin
                overflow_nxt = 1'b1;
              end
            end
            OP_SCORE: begin
              swap_nxt = swap_now;
              len1_nxt = len1_now;
              len2_nxt = len2_now;
              i_nxt    = '0;
              k_nxt    = len1_now;
              if ({1'b0, len2_now} > {len1_now, 1'b0}) begin
                out_valid_nxt    = 1'b1;
                out_sim_nxt      = SCORE_REJECT;
                out_too_long_nxt = overflow_r;
                length_a_nxt     = '0;
                length_b_nxt     = '0;
                overflow_nxt     = 1'b0;
              end else if (len1_now == '0) begin
                state_nxt = ST_EVAL;
              end else begin
                state_nxt = ST_PRE_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PRE_RD: begin
        state_nxt = ST_PRE_CMP;
      end
      ST_PRE_CMP: begin
        if (alike) begin
          i_nxt     = i_inc;
          state_nxt = (i_inc < len1_r) ? ST_PRE_RD : ST_EVAL;
        end else begin
          state_nxt = ST_SUF_RD;
        end
      end
      ST_SUF_RD: begin
        state_nxt = ST_SUF_CMP;
      end
      ST_SUF_CMP: begin
        if (alike) begin
          k_nxt     = k_dec;
          state_nxt = (k_dec > i_r) ? ST_SUF_RD : ST_EVAL;
        end else begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (unmatched == '0 || {1'b0, len2_r} > {matched, 1'b0}) begin
          out_valid_nxt    = 1'b1;
          out_sim_nxt      = (unmatched == '0) ? SCORE_FULL : SCORE_REJECT;
          out_too_long_nxt = overflow_r;
          length_a_nxt     = '0;
          length_b_nxt     = '0;
          overflow_nxt     = 1'b0;
          state_nxt        = ST_IDLE;
        end else begin
          tol_nxt   = tol_now;
          neg_nxt   = unmatched > tol_now;
          quo_nxt   = (unmatched > tol_now) ? {unmatched - tol_now, SCALE_SH'(0)}
                                            : {tol_now - unmatched, SCALE_SH'(0)};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt = quo_step;
        rem_nxt = qbit ? LEN_W'(trial - {1'b0, tol_r}) : LEN_W'(trial);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          out_valid_nxt    = 1'b1;
          out_sim_nxt      = neg_r ? -$signed(quo_mag) : $signed(quo_mag);
          out_too_long_nxt = overflow_r;
          length_a_nxt     = '0;
          length_b_nxt     = '0;
          overflow_nxt     = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      length_a_r  <= '0;
      length_b_r  <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      length_a_r  <= length_a_nxt;
      length_b_r  <= length_b_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
    swap_r         <= swap_nxt;
    len1_r         <= len1_nxt;
    len2_r         <= len2_nxt;
    i_r            <= i_nxt;
    k_r            <= k_nxt;
    tol_r          <= tol_nxt;
    neg_r          <= neg_nxt;
    quo_r          <= quo_nxt;
    rem_r          <= rem_nxt;
    cnt_r          <= cnt_nxt;
    out_sim_r      <= out_sim_nxt;
    out_too_long_r <= out_too_long_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_similarity = out_sim_r;
  assign out_too_long   = out_too_long_r;

`ifndef SYNTHESIS
  a_result_needs_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start && in_op == OP_SCORE)))
    else $error("result strobe without a score transaction");

  a_result_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && length_a_r == '0 && length_b_r == '0 && !overflow_r)
    else $error("buffers not cleared after result");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (length_a_r <= LEN_W'(MAX_LEN)) && (length_b_r <= LEN_W'(MAX_LEN)))
    else $error("name length beyond buffer depth");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUF_RD) |-> (k_r > i_r) && (k_r <= len1_r))
    else $error("suffix walk overlaps prefix");
`endif

endmodule

/* tb/sv/tb_name_similarity_score.sv */
// tb_name_similarity_score: self-checking testbench for name_similarity_score, with a directed
// table, then random name pairs and op bursts; results checked vs table answers or a local predictor
// depends on nss_pkg and name_similarity_score only
module tb_name_similarity_score;
  timeunit 1ns;
  timeprecision 1ps;

  import nss_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1500;
  localparam int LATENCY_TAIL = 2 * MAX_LEN + 40;
  localparam int MAX_GAP = 18;

  typedef struct packed {
    logic signed [SIM_W-1:0] sim;
    logic                    too_long;
  } score_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [CHAR_W-1:0]       ch;
    logic                    has_answer;
    logic signed [SIM_W-1:0] sim;
    logic                    too_long;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [OP_W-1:0] in_op = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic busy;
  logic out_valid;
  logic signed [SIM_W-1:0] out_similarity;
  logic out_too_long;

  logic [CHAR_W-1:0] names_a [MAX_LEN];
  logic [CHAR_W-1:0] names_b [MAX_LEN];
  int len_a = 0;
  int len_b = 0;
  bit long_seen = 1'b0;
  score_t score_q[$];
  int errors = 0;
  int items_done = 0;
  bit burst = 1'b0;

  plan_row_t plan [25] = '{
    '{OP_SCORE,  16'h0000, 1'b1, SCORE_FULL,   1'b0},
    '{OP_LOAD_A, 16'h0061, 1'b0, 10'sd0,       1'b0},
    '{OP_SCORE,  16'h0000, 1'b1, SCORE_REJECT, 1'b0},
    '{OP_LOAD_B, 16'h0041, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_A, 16'h0061, 1'b0, 10'sd0,       1'b0},
    '{OP_SCORE,  16'h0000, 1'b1, SCORE_FULL,   1'b0},
    '{OP_LOAD_A, 16'h0000, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_A, 16'hFFFF, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_B, 16'h0000, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_B, 16'hFFFF, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_A, 16'h005A, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_B, 16'h007A, 1'b0, 10'sd0,       1'b0},
    '{OP_SCORE,  16'hFFFF, 1'b1, SCORE_FULL,   1'b0},
    '{OP_LOAD_A, 16'h0040, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_B, 16'h0060, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_A, 16'h005B, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_B, 16'h007B, 1'b0, 10'sd0,       1'b0},
    '{OP_SCORE,  16'h0000, 1'b0, 10'sd0,       1'b0},
    '{OP_UNUSED, 16'hFFFF, 1'b0, 10'sd0,       1'b0},
    '{OP_SCORE,  16'hFFFF, 1'b1, SCORE_FULL,   1'b0},
    '{OP_LOAD_A, 16'h0078, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_B, 16'h0058, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_B, 16'h0079, 1'b0, 10'sd0,       1'b0},
    '{OP_LOAD_B, 16'h007A, 1'b0, 10'sd0,       1'b0},
    '{OP_SCORE,  16'h0000, 1'b1, SCORE_REJECT, 1'b0}
  };

  name_similarity_score i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_char_code  (in_char_code),
    .out_valid     (out_valid),
    .out_similarity(out_similarity),
    .out_too_long  (out_too_long)
  );

  always #6 clk = ~clk;

  function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
    if (c >= 16'h0041 && c <= 16'h005A) begin
      return c + 16'h0020;
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] flip_case(input logic [CHAR_W-1:0] c);
    if (c >= 16'h0041 && c <= 16'h005A) begin
      return c + 16'h0020;
    end
    if (c >= 16'h0061 && c <= 16'h007A) begin
      return c - 16'h0020;
    end
    return c;
  endfunction

  function automatic logic signed [SIM_W-1:0] score_names();
    logic [CHAR_W-1:0] s1 [MAX_LEN];
    logic [CHAR_W-1:0] s2 [MAX_LEN];
    int n1, n2, i, k, diff, hits, tol, val;
    if (len_a > len_b) begin
      s1 = names_b; n1 = len_b;
      s2 = names_a; n2 = len_a;
    end else begin
      s1 = names_a; n1 = len_a;
      s2 = names_b; n2 = len_b;
    end
    if (n2 > 2 * n1) begin
      return SCORE_REJECT;
    end
    hits = 0;
    i = 0;
    while (i < n1 && lower_ascii(s1[i]) == lower_ascii(s2[i])) begin
      i++;
      hits++;
    end
    k = n1;
    diff = n2 - n1;
    while (k > i && lower_ascii(s1[k-1]) == lower_ascii(s2[k+diff-1])) begin
      k--;
      hits++;
    end
    if (hits == n1) begin
      return SCORE_FULL;
    end
    if (n2 - hits > hits) begin
      return SCORE_REJECT;
    end
    tol = n1 / 4 + 1;
    val = ((tol - (k - i)) * 256) / tol;
    return val[SIM_W-1:0];
  endfunction

  task automatic track_transaction(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                   input logic has_answer, input logic signed [SIM_W-1:0] sim,
                                   input logic too_long);
    score_t want;
    case (op)
      OP_LOAD_A: begin
        if (len_a < MAX_LEN) begin
          names_a[len_a] = ch;
          len_a++;
        end else begin
          long_seen = 1'b1;
        end
      end
      OP_LOAD_B: begin
        if (len_b < MAX_LEN) begin
          names_b[len_b] = ch;
          len_b++;
        end else begin
          long_seen = 1'b1;
        end
      end
      OP_SCORE: begin
        want.sim = score_names();
        want.too_long = long_seen;
        if (has_answer) begin
          want.sim = sim;
          want.too_long = too_long;
        end
        score_q.push_back(want);
        len_a = 0;
        len_b = 0;
        long_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // called at a falling edge, returns at the falling edge after the transaction is taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic has_answer = 1'b0,
                           input logic signed [SIM_W-1:0] sim = '0,
                           input logic too_long = 1'b0);
    int gap;
    gap = burst ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_char_code <= ch;
    do @(posedge clk); while (busy !== 1'b0);
    track_transaction(op, ch, has_answer, sim, too_long);
    if (op != OP_UNUSED) begin
      items_done++;
    end
    @(negedge clk);
  endtask

  task automatic drain_scores();
    start <= 1'b0;
    @(negedge clk);
    while (score_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    logic [CHAR_W-1:0] edges [6] = '{16'h0040, 16'h005B, 16'h0060, 16'h007B, 16'h0000, 16'hFFFF};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'h0041 + 16'($urandom_range(0, 25));
      4, 5, 6:    return 16'h0061 + 16'($urandom_range(0, 25));
      7:          return edges[$urandom_range(0, 5)];
      default:    return 16'($urandom);
    endcase
  endfunction

  task automatic run_name_pair();
    logic [CHAR_W-1:0] first[$];
    logic [CHAR_W-1:0] second[$];
    logic [CHAR_W-1:0] c;
    int n, sel, pos, ia, ib;
    bit a_first, to_a;
    sel = $urandom_range(0, 9);
    n = (sel < 7) ? $urandom_range(0, 10) : (sel < 9) ? $urandom_range(11, 40)
                                                     : $urandom_range(60, 70);
    repeat (n) first.push_back(pick_char());
    foreach (first[j]) begin
      second.push_back(($urandom_range(0, 2) == 0) ? flip_case(first[j]) : first[j]);
    end
    case ($urandom_range(0, 4))
      1: begin
        if (n > 0) begin
          repeat ($urandom_range(1, 3)) second[$urandom_range(0, n - 1)] = pick_char();
        end
      end
      2: begin
        pos = $urandom_range(0, second.size());
        repeat ($urandom_range(1, n / 2 + 1)) second.insert(pos, pick_char());
      end
      3: begin
        repeat ($urandom_range(1, n / 2 + 1)) begin
          if (second.size() > 0) begin
            second.delete($urandom_range(0, second.size() - 1));
          end
        end
      end
      4: begin
        second.delete();
        repeat ($urandom_range(0, n + 3)) second.push_back(pick_char());
      end
      default: ;
    endcase
    while (second.size() > MAX_LEN + 6) void'(second.pop_back());
    a_first = $urandom_range(0, 1);
    ia = 0;
    ib = 0;
    while (ia < first.size() || ib < second.size()) begin
      to_a = (ib >= second.size()) || (ia < first.size() && $urandom_range(0, 1) == 1);
      if (to_a) begin
        c = first[ia];
        ia++;
      end else begin
        c = second[ib];
        ib++;
      end
      send_item((to_a == a_first) ? OP_LOAD_A : OP_LOAD_B, c);
      if ($urandom_range(0, 39) == 0) begin
        send_item(OP_UNUSED, 16'($urandom));
      end
    end
    send_item(OP_SCORE, 16'($urandom));
  endtask

  // result checking against the oldest pending score
  always @(posedge clk) begin
    score_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (score_q.size() == 0) begin
        flag_error($sformatf("result with none pending: similarity=%0d too_long=%0b",
                             out_similarity, out_too_long));
      end else begin
        want = score_q.pop_front();
        if (out_similarity !== want.sim) begin
          flag_error($sformatf("similarity %0d, predicted %0d", out_similarity, want.sim));
        end
        if (out_too_long !== want.too_long) begin
          flag_error($sformatf("too_long %0b, predicted %0b", out_too_long, want.too_long));
        end
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[r]) begin
      send_item(plan[r].op, plan[r].ch, plan[r].has_answer, plan[r].sim, plan[r].too_long);
    end
    drain_scores();

    while (items_done < ITEM_TARGET) begin
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) begin
        drain_scores();
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 12)) send_item(OP_W'($urandom_range(0, 3)), 16'($urandom));
      end else begin
        run_name_pair();
      end
    end

    drain_scores();
    repeat (LATENCY_TAIL) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout, %0d scores still pending", score_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
